[hdl/gcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int SQRT_STEPS        = 31;
  localparam int ROT_LANES         = 5;

  // Lane order of the rotation chain.
  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LATA = 2;
  localparam int LANE_LATB = 3;
  localparam int LANE_MEAN = 4;

  localparam int CW = 34;   // CORDIC datapath width
  localparam int VW = 61;   // square root radicand width (Q60 up to 1.0)
  localparam int RW = 62;   // square root partial root width

  typedef logic signed [CW-1:0] cval_t;
  typedef logic [4:0]           step_t;
  typedef logic [VW-1:0]        sq_val_t;
  typedef logic [RW-1:0]        sq_root_t;
  typedef logic [21:0]          radius_t;
  typedef logic [31:0]          rfrac_t;
  typedef logic [22:0]          dist_t;
  typedef logic [0:0]           reg_index_t;

  localparam reg_index_t REG_RADIUS_LOW  = 1'b0;
  localparam reg_index_t REG_RADIUS_HIGH = 1'b1;

  localparam radius_t RADIUS_LOW_RESET  = 22'd1630976;
  localparam radius_t RADIUS_HIGH_RESET = 22'd1632803;

  localparam cval_t      CORDIC_GAIN = 34'sh026DD3B6A;
  localparam cval_t      ONE_Q30     = 34'sh040000000;
  localparam logic [30:0] PI_Q29     = 31'd1686629713;
  localparam dist_t      DIST_MAX    = 23'd8388607;

  typedef struct packed {
    logic  flip;
    cval_t x;
    cval_t y;
    cval_t z;
  } rot_lane_t;

  typedef struct packed {
    sq_val_t  v;
    sq_root_t r;
  } sq_lane_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } vec_lane_t;

  // Arctangent of 2^-i in binary-angle units.
  function automatic cval_t atan_at(step_t i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return cval_t'({2'b00, a});
  endfunction

endpackage

`default_nettype wire

[hdl/gcd_point_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gcd_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lat_a;
  logic signed [31:0] lon_a;
  logic signed [31:0] lat_b;
  logic signed [31:0] lon_b;

  modport source(output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink(input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

`default_nettype wire

[hdl/gcd_dist_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gcd_dist_if;
  logic        valid;
  logic        ready;
  logic [22:0] distance;

  modport source(output valid, distance, input ready);
  modport sink(input valid, distance, output ready);
endinterface

`default_nettype wire

[hdl/gcd_rot_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcd_rot_cell (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  gcd_pkg::step_t                                  step,
  input  logic                                            valid_in,
  input  gcd_pkg::rot_lane_t [gcd_pkg::ROT_LANES-1:0]     lanes_in,
  output logic                                            valid_out,
  output gcd_pkg::rot_lane_t [gcd_pkg::ROT_LANES-1:0]     lanes_out
);

  gcd_pkg::rot_lane_t [gcd_pkg::ROT_LANES-1:0] lanes_next;

  always_comb begin
    gcd_pkg::cval_t x, y, z, dx, dy, at;
    at = gcd_pkg::atan_at(step);
    for (int i = 0; i < gcd_pkg::ROT_LANES; i++) begin
      x  = lanes_in[i].x;
      y  = lanes_in[i].y;
      z  = lanes_in[i].z;
      dx = y >>> step;
      dy = x >>> step;
      lanes_next[i].flip = lanes_in[i].flip;
      if (!z[gcd_pkg::CW-1]) begin
        lanes_next[i].x = x - dx;
        lanes_next[i].y = y + dy;
        lanes_next[i].z = z - at;
      end else begin
        lanes_next[i].x = x + dx;
        lanes_next[i].y = y - dy;
        lanes_next[i].z = z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_out <= lanes_next;
    end
  end

endmodule

`default_nettype wire

[hdl/gcd_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcd_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  gcd_pkg::step_t              step,
  input  logic                        valid_in,
  input  gcd_pkg::sq_lane_t [1:0]     lanes_in,
  input  gcd_pkg::rfrac_t             radius_in,
  output logic                        valid_out,
  output gcd_pkg::sq_lane_t [1:0]     lanes_out,
  output gcd_pkg::rfrac_t             radius_out
);

  localparam int ROOT_TOP = gcd_pkg::RW - 2;

  gcd_pkg::sq_lane_t [1:0] lanes_next;

  // One result bit per cell: the trial bit is 4^(30 - step).
  always_comb begin
    logic [5:0]        shamt;
    gcd_pkg::sq_root_t bitv, trial;
    shamt = 6'(ROOT_TOP) - {step, 1'b0};
    bitv  = gcd_pkg::sq_root_t'(1) << shamt;
    for (int i = 0; i < 2; i++) begin
      trial = lanes_in[i].r + bitv;
      if ({1'b0, lanes_in[i].v} >= trial) begin
        lanes_next[i].v = lanes_in[i].v - trial[gcd_pkg::VW-1:0];
        lanes_next[i].r = (lanes_in[i].r >> 1) + bitv;
      end else begin
        lanes_next[i].v = lanes_in[i].v;
        lanes_next[i].r = lanes_in[i].r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_out  <= lanes_next;
      radius_out <= radius_in;
    end
  end

endmodule

`default_nettype wire

[hdl/gcd_vec_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcd_vec_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  gcd_pkg::step_t      step,
  input  logic                valid_in,
  input  gcd_pkg::vec_lane_t  lane_in,
  input  gcd_pkg::rfrac_t     radius_in,
  output logic                valid_out,
  output gcd_pkg::vec_lane_t  lane_out,
  output gcd_pkg::rfrac_t     radius_out
);

  gcd_pkg::vec_lane_t lane_next;

  always_comb begin
    gcd_pkg::cval_t x, y, z, dx, dy, at;
    at = gcd_pkg::atan_at(step);
    x  = lane_in.x;
    y  = lane_in.y;
    z  = lane_in.z;
    dx = y >>> step;
    dy = x >>> step;
    if (y > 0) begin
      lane_next.x = x + dx;
      lane_next.y = y - dy;
      lane_next.z = z + at;
    end else begin
      lane_next.x = x - dx;
      lane_next.y = y + dy;
      lane_next.z = z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out   <= lane_next;
      radius_out <= radius_in;
    end
  end

endmodule

`default_nettype wire

[hdl/great_circle_distance_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Haversine great-circle distance between two points given as 32-bit binary
// angles, returned in units of 2^-8 km and saturated at the top of 23 bits.
// The block takes one point pair per clock cycle while input ready is high and
// holds many pairs in flight; each result passes the input register, the row of
// 24 rotation CORDIC cells, four product stages, 31 square root cells, 24
// vectoring CORDIC cells, two scaling stages and the output register. A
// two-entry output buffer lets inputs keep flowing while a result waits; input
// ready drops only when both entries are full. The user must write the two
// radius registers through the write port only while no pair is in flight; the block does not enforce it.
module great_circle_distance_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  gcd_pkg::reg_index_t      wr_index,
  input  gcd_pkg::radius_t         wr_data,
  gcd_point_if.sink                points,
  gcd_dist_if.source               result
);

  localparam int N = gcd_pkg::CORDIC_ITERATIONS;
  localparam int S = gcd_pkg::SQRT_STEPS;

  gcd_pkg::radius_t radius_low;
  gcd_pkg::radius_t radius_high;

  logic en;
  logic skid_valid;
  logic out_valid;
  gcd_pkg::dist_t skid_dist;
  gcd_pkg::dist_t out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_low  <= gcd_pkg::RADIUS_LOW_RESET;
      radius_high <= gcd_pkg::RADIUS_HIGH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        gcd_pkg::REG_RADIUS_LOW:  radius_low  <= wr_data;
        gcd_pkg::REG_RADIUS_HIGH: radius_high <= wr_data;
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid;
  assign points.ready = en;

  // Fold an angle into the right half-plane for rotation.
  function automatic gcd_pkg::rot_lane_t fold(logic [31:0] t);
    gcd_pkg::rot_lane_t l;
    logic [31:0] tf;
    l.flip = t[31] ^ t[30];
    tf     = {t[31] ^ l.flip, t[30:0]};
    l.x    = gcd_pkg::CORDIC_GAIN;
    l.y    = '0;
    l.z    = gcd_pkg::cval_t'($signed(tf));
    return l;
  endfunction

  function automatic gcd_pkg::cval_t unfold_x(gcd_pkg::rot_lane_t l);
    return l.flip ? -l.x : l.x;
  endfunction

  function automatic gcd_pkg::cval_t unfold_y(gcd_pkg::rot_lane_t l);
    return l.flip ? -l.y : l.y;
  endfunction

  // ---------------- input stage and rotation chain ----------------
  logic                                              rot_valid [N+1];
  gcd_pkg::rot_lane_t [gcd_pkg::ROT_LANES-1:0]       rot_lanes [N+1];
  gcd_pkg::rot_lane_t [gcd_pkg::ROT_LANES-1:0]       in_lanes;

  always_comb begin
    logic [31:0]        dlat, dlon;
    logic signed [32:0] sum, half;
    dlat = 32'(points.lat_b - points.lat_a);
    dlon = 32'(points.lon_b - points.lon_a);
    sum  = 33'(points.lat_a) + 33'(points.lat_b);
    // Halve toward zero.
    half = (sum + 33'(sum[32])) >>> 1;
    in_lanes[gcd_pkg::LANE_DLAT] = fold({1'b0, dlat[31:1]});
    in_lanes[gcd_pkg::LANE_DLON] = fold({1'b0, dlon[31:1]});
    in_lanes[gcd_pkg::LANE_LATA] = fold(points.lat_a);
    in_lanes[gcd_pkg::LANE_LATB] = fold(points.lat_b);
    in_lanes[gcd_pkg::LANE_MEAN] = fold(half[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid[0] <= 1'b0;
    end else if (en) begin
      rot_valid[0] <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_lanes[0] <= in_lanes;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_rot
    gcd_rot_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .step      (gcd_pkg::step_t'(g)),
      .valid_in  (rot_valid[g]),
      .lanes_in  (rot_lanes[g]),
      .valid_out (rot_valid[g+1]),
      .lanes_out (rot_lanes[g+1])
    );
  end

  // ---------------- product stages ----------------
  logic                 m1_valid, m2_valid, m3_valid, m4_valid;
  logic signed [67:0]   m1_cacb, m1_s1sq, m2_s1sq, m3_s1sq;
  logic signed [67:0]   m2_p, m3_p;
  gcd_pkg::cval_t       m1_s2, m2_s2;
  logic [53:0]          m1_t_low, m1_t_high;
  gcd_pkg::rfrac_t      m2_rf, m3_rf, m4_rf;
  gcd_pkg::sq_val_t     m4_a, m4_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= rot_valid[N];
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    gcd_pkg::cval_t ca, cb, cm, s1, cl, ph;
    logic [31:0]        wl, wh;
    logic signed [67:0] a;
    ca = unfold_x(rot_lanes[N][gcd_pkg::LANE_LATA]);
    cb = unfold_x(rot_lanes[N][gcd_pkg::LANE_LATB]);
    cm = unfold_x(rot_lanes[N][gcd_pkg::LANE_MEAN]);
    s1 = unfold_y(rot_lanes[N][gcd_pkg::LANE_DLAT]);
    if (cm > gcd_pkg::ONE_Q30) begin
      cm = gcd_pkg::ONE_Q30;
    end else if (cm < -gcd_pkg::ONE_Q30) begin
      cm = -gcd_pkg::ONE_Q30;
    end
    wl = 32'(gcd_pkg::ONE_Q30 + cm);
    wh = 32'(gcd_pkg::ONE_Q30 - cm);
    cl = gcd_pkg::cval_t'(m1_cacb >>> 30);
    ph = gcd_pkg::cval_t'(m2_p >>> 30);
    a  = m3_s1sq + m3_p;
    if (en) begin
      m1_cacb   <= 68'(ca) * 68'(cb);
      m1_s1sq   <= 68'(s1) * 68'(s1);
      m1_s2     <= unfold_y(rot_lanes[N][gcd_pkg::LANE_DLON]);
      m1_t_low  <= 54'(radius_low) * 54'(wl);
      m1_t_high <= 54'(radius_high) * 54'(wh);

      m2_p      <= 68'(cl) * 68'(m1_s2);
      m2_s2     <= m1_s2;
      m2_s1sq   <= m1_s1sq;
      m2_rf     <= gcd_pkg::rfrac_t'((55'(m1_t_low) + 55'(m1_t_high)) >> 23);

      m3_p      <= 68'(ph) * 68'(m2_s2);
      m3_s1sq   <= m2_s1sq;
      m3_rf     <= m2_rf;

      // Clamp a to [0, 1] in Q60 and form 1 - a.
      if (a[67]) begin
        m4_a <= '0;
      end else if (a > (68'sd1 <<< 60)) begin
        m4_a <= gcd_pkg::sq_val_t'(1) << 60;
      end else begin
        m4_a <= a[gcd_pkg::VW-1:0];
      end
      if (a[67]) begin
        m4_b <= gcd_pkg::sq_val_t'(1) << 60;
      end else if (a > (68'sd1 <<< 60)) begin
        m4_b <= '0;
      end else begin
        m4_b <= (gcd_pkg::sq_val_t'(1) << 60) - a[gcd_pkg::VW-1:0];
      end
      m4_rf     <= m3_rf;
    end
  end

  // ---------------- square root chain ----------------
  logic                       sq_valid [S+1];
  gcd_pkg::sq_lane_t [1:0]    sq_lanes [S+1];
  gcd_pkg::rfrac_t            sq_rf    [S+1];

  assign sq_valid[0]      = m4_valid;
  assign sq_lanes[0][0].v = m4_a;
  assign sq_lanes[0][0].r = '0;
  assign sq_lanes[0][1].v = m4_b;
  assign sq_lanes[0][1].r = '0;
  assign sq_rf[0]         = m4_rf;

  for (genvar g = 0; g < S; g++) begin : g_sqrt
    gcd_sqrt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .step       (gcd_pkg::step_t'(g)),
      .valid_in   (sq_valid[g]),
      .lanes_in   (sq_lanes[g]),
      .radius_in  (sq_rf[g]),
      .valid_out  (sq_valid[g+1]),
      .lanes_out  (sq_lanes[g+1]),
      .radius_out (sq_rf[g+1])
    );
  end

  // ---------------- vectoring chain ----------------
  logic                   vec_valid [N+1];
  gcd_pkg::vec_lane_t     vec_lane  [N+1];
  gcd_pkg::rfrac_t        vec_rf    [N+1];

  assign vec_valid[0]  = sq_valid[S];
  assign vec_lane[0].x = gcd_pkg::cval_t'({3'b000, sq_lanes[S][1].r[30:0]});
  assign vec_lane[0].y = gcd_pkg::cval_t'({3'b000, sq_lanes[S][0].r[30:0]});
  assign vec_lane[0].z = '0;
  assign vec_rf[0]     = sq_rf[S];

  for (genvar g = 0; g < N; g++) begin : g_vec
    gcd_vec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .step       (gcd_pkg::step_t'(g)),
      .valid_in   (vec_valid[g]),
      .lane_in    (vec_lane[g]),
      .radius_in  (vec_rf[g]),
      .valid_out  (vec_valid[g+1]),
      .lane_out   (vec_lane[g+1]),
      .radius_out (vec_rf[g+1])
    );
  end

  // ---------------- scaling stages ----------------
  logic            f1_valid, f2_valid;
  logic [61:0]     f1_cq;
  gcd_pkg::rfrac_t f1_rf;
  logic [63:0]     f2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= vec_valid[N];
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    gcd_pkg::cval_t z;
    logic [30:0]    zc;
    z = vec_lane[N].z;
    if (z[gcd_pkg::CW-1]) begin
      zc = '0;
    end else if (z > gcd_pkg::ONE_Q30) begin
      zc = 31'(gcd_pkg::ONE_Q30);
    end else begin
      zc = z[30:0];
    end
    if (en) begin
      f1_cq   <= 62'(zc) * 62'(gcd_pkg::PI_Q29);
      f1_rf   <= vec_rf[N];
      f2_prod <= 64'(f1_cq[60:29]) * 64'(f1_rf);
    end
  end

  logic           p_valid;
  gcd_pkg::dist_t p_dist;

  always_comb begin
    logic [64:0] rounded;
    rounded = 65'(f2_prod) + (65'd1 << 37);
    if (rounded[64:38] > 27'(gcd_pkg::DIST_MAX)) begin
      p_dist = gcd_pkg::DIST_MAX;
    end else begin
      p_dist = rounded[60:38];
    end
  end

  assign p_valid = f2_valid && !skid_valid;

  // ---------------- output register and skid entry ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= p_valid;
      end
    end else if (p_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_dist <= skid_valid ? skid_dist : p_dist;
    end else if (p_valid) begin
      skid_dist <= p_dist;
    end
  end

  assign result.valid    = out_valid;
  assign result.distance = out_dist;

  // The skid entry only fills behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready))
    else $error("skid entry filled without a stalled output");

  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> (result.valid && !skid_valid))
    else $error("skid entry did not move to the output register");

  assert property (@(posedge clk) disable iff (rst)
    (f2_valid && en && out_valid && !result.ready) |=> skid_valid)
    else $error("finished result dropped while the output stalled");

endmodule

`default_nettype wire
